[hdl/lcd_registers_and_palette_lookup_unit_macros.svh]
// ----------------------------------------------------------------------------
// LCD register unit assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef LCD_REGISTERS_AND_PALETTE_LOOKUP_UNIT_MACROS_SVH
`define LCD_REGISTERS_AND_PALETTE_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCDPL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCDPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/lcdpl_pkg.sv]
// ----------------------------------------------------------------------------
// LCD register unit package
// Operation codes, register addresses, word layouts and the shade table.
// ----------------------------------------------------------------------------
package lcdpl_pkg;

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_RENDER = 2'd2,
		OP_MODE   = 2'd3
	} lcdpl_op_t;

	localparam logic [15:0] ADDR_CONTROL   = 16'hFF40;
	localparam logic [15:0] ADDR_STATUS    = 16'hFF41;
	localparam logic [15:0] ADDR_SCROLL_Y  = 16'hFF42;
	localparam logic [15:0] ADDR_SCROLL_X  = 16'hFF43;
	localparam logic [15:0] ADDR_LINE      = 16'hFF44;
	localparam logic [15:0] ADDR_LINE_CMP  = 16'hFF45;
	localparam logic [15:0] ADDR_BG_PAL    = 16'hFF47;
	localparam logic [15:0] ADDR_OBJ_PAL0  = 16'hFF48;
	localparam logic [15:0] ADDR_OBJ_PAL1  = 16'hFF49;
	localparam logic [15:0] ADDR_WIN_Y     = 16'hFF4A;
	localparam logic [15:0] ADDR_WIN_X     = 16'hFF4B;
	localparam logic [15:0] ADDR_BGP_INDEX = 16'hFF68;
	localparam logic [15:0] ADDR_BGP_DATA  = 16'hFF69;
	localparam logic [15:0] ADDR_OBP_INDEX = 16'hFF6A;
	localparam logic [15:0] ADDR_OBP_DATA  = 16'hFF6B;

	localparam logic [7:0] READ_UNMAPPED = 8'hFF;

	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 2;

	localparam int PAL_WORDS = 32;
	localparam int PAL_AW    = $clog2(PAL_WORDS);

	typedef struct packed {
		lcdpl_op_t   op;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [7:0]  pixel_x;
		logic [1:0]  pixel_code;
		logic        obj_sel;
		logic [2:0]  palette_number;
		logic [1:0]  new_mode;
	} lcdpl_item_t;

	// Bus read answer from one register group.
	typedef struct packed {
		logic       hit;
		logic [7:0] data;
	} lcdpl_rd_t;

	function automatic logic [15:0] shade(input logic [1:0] code);
		logic [15:0] c;
		case (code)
			2'd0:    c = 16'hEBFC;
			2'd1:    c = 16'hBB11;
			2'd2:    c = 16'hA9A6;
			default: c = 16'h9061;
		endcase
		return c;
	endfunction

endpackage

[hdl/lcdpl_regs.sv]
// ----------------------------------------------------------------------------
// LCD register unit: display registers
// Control, status, line, compare, scroll, window and monochrome palettes.
// ----------------------------------------------------------------------------
module lcdpl_regs (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcdpl_pkg::lcdpl_item_t item,
	input  logic                   fire,
	output lcdpl_pkg::lcdpl_rd_t   rd,
	output logic [7:0]             line,
	output logic [2:0][7:0]        mono_pal
);
	import lcdpl_pkg::*;

	logic [7:0]      control_q, line_q, line_cmp_q, status_q;
	logic [7:0]      scroll_y_q, scroll_x_q, win_y_q, win_x_q;
	logic [2:0][7:0] mono_q;
	logic            wr, mode_set;

	assign wr       = fire && (item.op == OP_WRITE);
	assign mode_set = fire && (item.op == OP_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q  <= '0;
			line_q     <= '0;
			line_cmp_q <= '0;
			status_q   <= '0;
			scroll_y_q <= '0;
			scroll_x_q <= '0;
			win_y_q    <= '0;
			win_x_q    <= '0;
			mono_q     <= '0;
		end else begin
			if (wr) begin
				case (item.address)
					ADDR_CONTROL: begin
						control_q <= item.write_data;
						// Turning the display off restarts the line count and mode.
						if (!item.write_data[7]) begin
							line_q        <= '0;
							status_q[1:0] <= '0;
						end
					end
					ADDR_STATUS:   status_q[7:2] <= item.write_data[7:2];
					ADDR_SCROLL_Y: scroll_y_q    <= item.write_data;
					ADDR_SCROLL_X: scroll_x_q    <= item.write_data;
					ADDR_LINE:     line_q        <= item.write_data;
					ADDR_LINE_CMP: line_cmp_q    <= item.write_data;
					ADDR_BG_PAL:   mono_q[0]     <= item.write_data;
					ADDR_OBJ_PAL0: mono_q[1]     <= item.write_data;
					ADDR_OBJ_PAL1: mono_q[2]     <= item.write_data;
					ADDR_WIN_Y:    win_y_q       <= item.write_data;
					ADDR_WIN_X:    win_x_q       <= item.write_data;
					default: ;
				endcase
			end
			if (mode_set) begin
				status_q[1:0] <= item.new_mode;
			end
		end
	end

	always_comb begin
		rd.hit  = 1'b1;
		rd.data = READ_UNMAPPED;
		case (item.address)
			ADDR_CONTROL:  rd.data = control_q;
			ADDR_STATUS:   rd.data = status_q | 8'h80;
			ADDR_SCROLL_Y: rd.data = scroll_y_q;
			ADDR_SCROLL_X: rd.data = scroll_x_q;
			ADDR_LINE:     rd.data = line_q;
			ADDR_LINE_CMP: rd.data = line_cmp_q;
			ADDR_BG_PAL:   rd.data = mono_q[0];
			ADDR_OBJ_PAL0: rd.data = mono_q[1];
			ADDR_OBJ_PAL1: rd.data = mono_q[2];
			ADDR_WIN_Y:    rd.data = win_y_q;
			ADDR_WIN_X:    rd.data = win_x_q;
			default:       rd.hit  = 1'b0;
		endcase
	end

	assign line     = line_q;
	assign mono_pal = mono_q;

endmodule

[hdl/lcdpl_cpal.sv]
// ----------------------------------------------------------------------------
// LCD register unit: color palettes
// Index registers and the background and object palette words.
// ----------------------------------------------------------------------------
module lcdpl_cpal (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lcdpl_pkg::lcdpl_item_t item,
	input  logic                   fire,
	input  logic                   color_mode,
	output lcdpl_pkg::lcdpl_rd_t   rd,
	output logic [15:0]            color
);
	import lcdpl_pkg::*;

	logic [1:0][7:0]    idx_q;
	logic [15:0]        bg_q  [PAL_WORDS];
	logic [15:0]        obj_q [PAL_WORDS];
	logic               data_sel, rsel, render, wr, data_wr;
	logic [5:0]         cur_idx, nxt_idx;
	logic [PAL_AW-1:0]  raddr, waddr;
	logic [15:0]        word;

	assign data_sel = (item.address == ADDR_OBP_DATA);
	assign cur_idx  = idx_q[data_sel][5:0];
	assign nxt_idx  = cur_idx + 6'd1;
	assign render   = (item.op == OP_RENDER);

	// One read port per table: the render lookup or the data register.
	assign rsel  = render ? item.obj_sel : data_sel;
	assign raddr = render ? {item.palette_number, item.pixel_code} : cur_idx[5:1];
	assign word  = rsel ? obj_q[raddr] : bg_q[raddr];
	assign color = word;

	assign wr      = fire && (item.op == OP_WRITE) && color_mode;
	assign data_wr = wr && ((item.address == ADDR_BGP_DATA) ||
		(item.address == ADDR_OBP_DATA));
	assign waddr   = cur_idx[5:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (wr) begin
			case (item.address)
				ADDR_BGP_INDEX: idx_q[0] <= item.write_data;
				ADDR_OBP_INDEX: idx_q[1] <= item.write_data;
				ADDR_BGP_DATA, ADDR_OBP_DATA: begin
					// Auto-increment keeps bit 7 and clears bit 6.
					if (idx_q[data_sel][7]) begin
						idx_q[data_sel] <= {2'b10, nxt_idx};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (data_wr) begin
			if (data_sel) begin
				if (cur_idx[0]) begin
					obj_q[waddr][15:8] <= item.write_data | 8'h80;
				end else begin
					obj_q[waddr][7:0] <= item.write_data;
				end
			end else begin
				if (cur_idx[0]) begin
					bg_q[waddr][15:8] <= item.write_data | 8'h80;
				end else begin
					bg_q[waddr][7:0] <= item.write_data;
				end
			end
		end
	end

	always_comb begin
		rd.hit  = color_mode;
		rd.data = READ_UNMAPPED;
		case (item.address)
			ADDR_BGP_INDEX: rd.data = idx_q[0] | 8'h40;
			ADDR_OBP_INDEX: rd.data = idx_q[1] | 8'h40;
			ADDR_BGP_DATA, ADDR_OBP_DATA: rd.data = cur_idx[0] ? word[15:8] : word[7:0];
			default: rd.hit = 1'b0;
		endcase
	end

endmodule

[hdl/lcdpl_render.sv]
// ----------------------------------------------------------------------------
// LCD register unit: pixel render
// Color selection, palette range check and frame-buffer address.
// ----------------------------------------------------------------------------
module lcdpl_render #(
	parameter int SCREEN_WIDTH = 160
) (
	input  lcdpl_pkg::lcdpl_item_t item,
	input  logic                   color_mode,
	input  logic [7:0]             line,
	input  logic [2:0][7:0]        mono_pal,
	input  logic [15:0]            pal_color,
	output logic [15:0]            pixel_color,
	output logic [15:0]            pixel_address,
	output logic                   pixel_valid,
	output logic                   palette_error
);
	import lcdpl_pkg::*;

	logic [16:0] addr_sum;
	logic [1:0]  mono_sel;
	logic [7:0]  pal;
	logic [1:0]  shade_code;
	logic        bad_pal;

	assign addr_sum      = 17'(line) * 17'(SCREEN_WIDTH) + 17'(item.pixel_x);
	assign pixel_address = addr_sum[15:0];

	assign mono_sel   = item.obj_sel ? (item.palette_number[0] ? 2'd2 : 2'd1) : 2'd0;
	assign pal        = mono_pal[mono_sel];
	assign shade_code = pal[{item.pixel_code, 1'b0} +: 2];

	// Monochrome has one background and two object palettes.
	assign bad_pal = item.obj_sel ? (item.palette_number > 3'd1)
		: (item.palette_number != 3'd0);

	always_comb begin
		if (color_mode) begin
			pixel_color   = pal_color;
			pixel_valid   = 1'b1;
			palette_error = 1'b0;
		end else begin
			pixel_color   = bad_pal ? 16'h0000 : shade(shade_code);
			pixel_valid   = !bad_pal;
			palette_error = bad_pal;
		end
	end

endmodule

[hdl/lcd_registers_and_palette_lookup_unit.sv]
// ----------------------------------------------------------------------------
// LCD registers and palette lookup unit
// Register file of an LCD controller with color palette lookup.
// ----------------------------------------------------------------------------
// Each input word on the s_axis channel is one operation, picked by tuser:
// a bus read, a bus write, a pixel render or a display mode set. Every input
// word yields exactly one output word on the m_axis channel, carrying the read
// byte, the pixel color and frame-buffer address, and the valid and error
// flags; fields that an operation does not produce are zero.
// The color-mode register is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while the unit is idle, which the block does not enforce.
// An accepted word is held in the input register, is executed by
// single-pass logic against the register file and the palette tables, and
// lands in the output register. Throughput is one word per cycle while the
// receiver does not stall, set by the single execute step between these two
// registers; register updates happen at the edge where the result is
// captured, so each word sees all earlier writes.
// When the receiver stalls, the output word holds and the input register can
// still take one more word; after that s_axis_tready drops until m_axis_tready
// returns. Reset clears the registers and the pipeline valid bits; palette
// words are undefined until written.
// ----------------------------------------------------------------------------
module lcd_registers_and_palette_lookup_unit #(
	parameter int SCREEN_WIDTH = 160
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic                             cfg_wr_data,    // color_mode
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// address[15:0] write_data[23:16] pixel_x[31:24] pixel_code[33:32]
	// obj_sel[34] palette_number[37:35] new_mode[39:38]
	input  logic [lcdpl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [lcdpl_pkg::IN_USER_W-1:0]  s_axis_tuser,   // operation[1:0]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// read_data[7:0] pixel_color[23:8] pixel_address[39:24]
	output logic [lcdpl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// pixel_valid[0] palette_error[1]
	output logic [lcdpl_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import lcdpl_pkg::*;

	logic                  color_mode_q;
	logic                  valid_s1;
	lcdpl_item_t           item_in, item_s1;
	logic                  advance, fire, in_take;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	lcdpl_rd_t             regs_rd, cpal_rd;
	logic [7:0]            line;
	logic [2:0][7:0]       mono_pal;
	logic [15:0]           pal_color;
	logic [15:0]           r_color, r_address;
	logic                  r_valid, r_error;

	logic                  is_read, is_render;
	logic [7:0]            read_data;
	logic [15:0]           pixel_color, pixel_address;
	logic                  pixel_valid, palette_error;

	// Unpack the input word.
	assign item_in.op             = lcdpl_op_t'(s_axis_tuser[1:0]);
	assign item_in.address        = s_axis_tdata[15:0];
	assign item_in.write_data     = s_axis_tdata[23:16];
	assign item_in.pixel_x        = s_axis_tdata[31:24];
	assign item_in.pixel_code     = s_axis_tdata[33:32];
	assign item_in.obj_sel        = s_axis_tdata[34];
	assign item_in.palette_number = s_axis_tdata[37:35];
	assign item_in.new_mode       = s_axis_tdata[39:38];

	// The output register is free, or is being emptied this cycle.
	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			color_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
	end

	lcdpl_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_s1),
		.fire     (fire),
		.rd       (regs_rd),
		.line     (line),
		.mono_pal (mono_pal)
	);

	lcdpl_cpal u_cpal (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.fire       (fire),
		.color_mode (color_mode_q),
		.rd         (cpal_rd),
		.color      (pal_color)
	);

	lcdpl_render #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_render (
		.item          (item_s1),
		.color_mode    (color_mode_q),
		.line          (line),
		.mono_pal      (mono_pal),
		.pal_color     (pal_color),
		.pixel_color   (r_color),
		.pixel_address (r_address),
		.pixel_valid   (r_valid),
		.palette_error (r_error)
	);

	// Result assembly: fields an operation does not produce read as zero.
	// An address that no register group claims reads as all ones, and so
	// do the color registers in monochrome mode.
	assign is_read   = (item_s1.op == OP_READ);
	assign is_render = (item_s1.op == OP_RENDER);

	always_comb begin
		read_data = 8'h00;
		if (is_read) begin
			if (regs_rd.hit) begin
				read_data = regs_rd.data;
			end else if (cpal_rd.hit) begin
				read_data = cpal_rd.data;
			end else begin
				read_data = READ_UNMAPPED;
			end
		end
	end

	assign pixel_color   = is_render ? r_color : 16'h0000;
	assign pixel_address = is_render ? r_address : 16'h0000;
	assign pixel_valid   = is_render && r_valid;
	assign palette_error = is_render && r_error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {pixel_address, pixel_color, read_data};
			out_user_q <= {palette_error, pixel_valid};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

[hdl/lcdpl_checker.sv]
// ----------------------------------------------------------------------------
// LCD register unit checker
// Port-level assertions on the output words, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcd_registers_and_palette_lookup_unit_macros.svh"

module lcdpl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [lcdpl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [lcdpl_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import lcdpl_pkg::*;

	// A stalled output word must hold.
	`LCDPL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")

	// A render either produces a color or flags the palette, never both.
	`LCDPL_ASSERT_IMPL(a_flags_excl, clk, arst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "pixel_valid and palette_error both set")

	// A palette error carries no color.
	`LCDPL_ASSERT_IMPL(a_err_no_color, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[23:8] == 16'h0000, "color present with palette error")

	// A word with read data is a bus read, so it has no pixel fields.
	`LCDPL_ASSERT_IMPL(a_read_only, clk, arst_n, m_axis_tvalid && (m_axis_tdata[7:0] != 8'h00), (m_axis_tdata[39:8] == 32'h0) && (m_axis_tuser == 2'b00), "read result mixed with pixel fields")

endmodule

bind lcd_registers_and_palette_lookup_unit lcdpl_checker u_lcdpl_checker (.*);
